// ===== hdl/radial_gradient_luma_top_defines.svh =====
// Assertion macros for the radial gradient luma block.
// No dependencies; included by the top level, which must provide clock and reset.
`ifndef RADIAL_GRADIENT_LUMA_TOP_DEFINES_SVH
`define RADIAL_GRADIENT_LUMA_TOP_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define RGL_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rgl check failed");

// antecedent holds -> consequent holds in the next cycle
`define RGL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rgl check failed");

`endif

// ===== hdl/rgl_pkg.sv =====
// Shared types and constants for the radial gradient luma block.
// No dependencies.
`timescale 1ns / 1ps

package rgl_pkg;

   localparam int COORD_W  = 12;
   localparam int CSR_IW   = 3;
   localparam int CSR_DW   = 32;
   localparam int RAD_W    = 60;   // radicand, padded to an even width
   localparam int ROOT_W   = 30;
   localparam int REM_W    = 31;
   localparam int SLOPE_W  = 17;
   localparam int LEVEL_W  = 24;
   localparam int RATIO_W  = 17;

   localparam logic [CSR_IW-1:0] REG_CENTER_X     = 3'd0;
   localparam logic [CSR_IW-1:0] REG_CENTER_Y     = 3'd1;
   localparam logic [CSR_IW-1:0] REG_INNER_RADIUS = 3'd2;
   localparam logic [CSR_IW-1:0] REG_OUTER_RADIUS = 3'd3;
   localparam logic [CSR_IW-1:0] REG_INNER_LEVEL  = 3'd4;
   localparam logic [CSR_IW-1:0] REG_OUTER_LEVEL  = 3'd5;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 24'hFF0000;
   localparam logic [SLOPE_W-1:0] ONE_FX    = 17'h10000;

   // word carried down the square root cell chain
   typedef struct packed {
      logic              valid;
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_word_type;

   // clamp a signed 16.16 level to 0..255 whole
   function automatic logic [LEVEL_W-1:0] clamp_level(input logic [CSR_DW-1:0] v);
      logic [LEVEL_W-1:0] r;
      if (v[CSR_DW-1])
         r = '0;
      else if (v > {8'h00, LEVEL_MAX})
         r = LEVEL_MAX;
      else
         r = v[LEVEL_W-1:0];
      return r;
   endfunction

endpackage

// ===== hdl/rgl_cell.sv =====
// One square root cell: retires one root bit per word and hands it on.
// Depends on rgl_pkg.
`timescale 1ns / 1ps

module rgl_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  rgl_pkg::sqrt_word_type word_in,
   output rgl_pkg::sqrt_word_type word_out
);

   logic [rgl_pkg::REM_W+1:0] rem_sh;
   logic [rgl_pkg::REM_W+1:0] trial;
   logic                      ge;
   rgl_pkg::sqrt_word_type    word_in_c;
   rgl_pkg::sqrt_word_type    word_ff;

   // bring down two radicand bits, try root*4+1
   always_comb begin
      rem_sh = {word_in.rem, word_in.rad[rgl_pkg::RAD_W-1 -: 2]};
      trial  = {1'b0, word_in.root, 2'b01};
      ge     = (rem_sh >= trial);
      word_in_c       = word_in;
      word_in_c.rad   = {word_in.rad[rgl_pkg::RAD_W-3:0], 2'b00};
      word_in_c.rem   = ge ? rgl_pkg::REM_W'(rem_sh - trial) : rgl_pkg::REM_W'(rem_sh);
      word_in_c.root  = {word_in.root[rgl_pkg::ROOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      word_ff.rad  <= word_in_c.rad;
      word_ff.rem  <= word_in_c.rem;
      word_ff.root <= word_in_c.root;
   end

   always_ff @(posedge clock) begin
      if (reset)
         word_ff.valid <= 1'b0;
      else
         word_ff.valid <= word_in.valid;
   end

   assign word_out = word_ff;

endmodule

// ===== hdl/rgl_slope_div.sv =====
// Slope unit: floor(2^32 / fade), one quotient bit per cycle.
// Depends on rgl_pkg.
`timescale 1ns / 1ps

module rgl_slope_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         restart,
   input  logic signed [30:0]           inner,
   input  logic signed [30:0]           outer,
   output logic [rgl_pkg::SLOPE_W-1:0]  slope,
   output logic                         busy
);

   localparam int STEPS = rgl_pkg::SLOPE_W;

   logic signed [31:0]               diff;
   logic [30:0]                      fade;
   logic [30:0]                      div_in,  div_ff;
   logic [30:0]                      rem_in,  rem_ff;
   logic [31:0]                      rem2;
   logic [rgl_pkg::SLOPE_W-1:0]      quo_in,  quo_ff;
   logic [rgl_pkg::SLOPE_W-1:0]      slope_in, slope_ff;
   logic [$clog2(STEPS)-1:0]         cnt_in,  cnt_ff;
   logic                             busy_in, busy_ff;

   always_comb begin
      diff = {outer[30], outer} - {inner[30], inner};
      fade = (diff <= 32'sd65536) ? 31'd65536 : diff[30:0];
      rem2 = {rem_ff, 1'b0};
      div_in   = div_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      slope_in = slope_ff;
      if (restart) begin
         // quotient fits 17 bits, so the bits above start from 2^15
         div_in  = fade;
         rem_in  = 31'd32768;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem2 >= {1'b0, div_ff}) begin
            rem_in = 31'(rem2 - {1'b0, div_ff});
            quo_in = {quo_ff[rgl_pkg::SLOPE_W-2:0], 1'b1};
         end else begin
            rem_in = rem2[30:0];
            quo_in = {quo_ff[rgl_pkg::SLOPE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(STEPS))'(STEPS - 1)) begin
            busy_in  = 1'b0;
            slope_in = quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         slope_ff <= rgl_pkg::ONE_FX;
      end else begin
         busy_ff  <= busy_in;
         slope_ff <= slope_in;
      end
   end

   assign slope = slope_ff;
   assign busy  = busy_ff;

endmodule

// ===== hdl/radial_gradient_luma_top.sv =====
// Radial gradient luma generator, top level.
// Depends on rgl_pkg, rgl_cell, rgl_slope_div and radial_gradient_luma_top_defines.svh.
//
//   channel   ports                               handshake
//   request   req_col, req_row                    start && !busy
//   response  rsp_luma                            rsp_strobe, one cycle, no stall
//   csr       csr_index, csr_wdata                csr_we, taken at once
//
// One word per cycle while busy is low; a word's luma is taken through
// three stages ahead of the 30-cell square root chain and five behind it.
// A write to either radius reruns the slope divider, and busy stays high
// until the new slope is ready. The response side cannot stall. Reset is synchronous and
// returns the registers to their reset values and empties the pipeline.
`timescale 1ns / 1ps
`include "radial_gradient_luma_top_defines.svh"

module radial_gradient_luma_top #(
   parameter int MAX_DIM = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rgl_pkg::COORD_W-1:0]   req_col,
   input  logic [rgl_pkg::COORD_W-1:0]   req_row,
   output logic                          rsp_strobe,
   output logic [7:0]                    rsp_luma,
   input  logic                          csr_we,
   input  logic [rgl_pkg::CSR_IW-1:0]    csr_index,
   input  logic [rgl_pkg::CSR_DW-1:0]    csr_wdata
);

   localparam int CELLS   = rgl_pkg::ROOT_W;
   localparam int LATENCY = CELLS + 8;

   // ---------------- configuration registers ----------------
   logic signed [28:0]             cx_ff, cy_ff;
   logic signed [30:0]             inner_ff, outer_ff;
   logic [rgl_pkg::LEVEL_W-1:0]    lin_ff, lout_ff;
   logic                           restart_ff;
   logic                           radius_wr;
   logic [rgl_pkg::SLOPE_W-1:0]    slope;
   logic                           div_busy;

   assign radius_wr = csr_we && (csr_index == rgl_pkg::REG_INNER_RADIUS ||
                                 csr_index == rgl_pkg::REG_OUTER_RADIUS);

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff      <= '0;
         cy_ff      <= '0;
         inner_ff   <= '0;
         outer_ff   <= 31'sd65536;
         lin_ff     <= '0;
         lout_ff    <= rgl_pkg::LEVEL_MAX;
         restart_ff <= 1'b0;
      end else begin
         restart_ff <= radius_wr;
         if (csr_we) begin
            unique case (csr_index)
               rgl_pkg::REG_CENTER_X:     cx_ff    <= csr_wdata[28:0];
               rgl_pkg::REG_CENTER_Y:     cy_ff    <= csr_wdata[28:0];
               rgl_pkg::REG_INNER_RADIUS: inner_ff <= csr_wdata[30:0];
               rgl_pkg::REG_OUTER_RADIUS: outer_ff <= csr_wdata[30:0];
               rgl_pkg::REG_INNER_LEVEL:  lin_ff   <= rgl_pkg::clamp_level(csr_wdata);
               rgl_pkg::REG_OUTER_LEVEL:  lout_ff  <= rgl_pkg::clamp_level(csr_wdata);
               default: ;   // unknown index: dropped
            endcase
         end
      end
   end

   rgl_slope_div u_div (
      .clock   (clock),
      .reset   (reset),
      .restart (restart_ff),
      .inner   (inner_ff),
      .outer   (outer_ff),
      .slope   (slope),
      .busy    (div_busy)
   );

   assign busy = restart_ff | div_busy;

   // ---------------- stage A: clip, center, abs ----------------
   logic                           accept;
   logic [rgl_pkg::COORD_W-1:0]    col_c, row_c;
   logic signed [29:0]             dx, dy;
   logic [28:0]                    ax_ff, ay_ff;
   logic                           va_ff;

   assign accept = start && !busy;

   always_comb begin
      col_c = (32'(req_col) >= MAX_DIM) ? rgl_pkg::COORD_W'(MAX_DIM - 1) : req_col;
      row_c = (32'(req_row) >= MAX_DIM) ? rgl_pkg::COORD_W'(MAX_DIM - 1) : req_row;
      // sample at pixel center: col*1.0 + 0.5 in 16.16
      dx = $signed({2'b00, col_c, 16'h8000}) - {cx_ff[28], cx_ff};
      dy = $signed({2'b00, row_c, 16'h8000}) - {cy_ff[28], cy_ff};
   end

   always_ff @(posedge clock) begin
      ax_ff <= dx[29] ? 29'(-dx) : dx[28:0];
      ay_ff <= dy[29] ? 29'(-dy) : dy[28:0];
   end

   // ---------------- stage B: squares ----------------
   logic [57:0] sqx_ff, sqy_ff;
   logic        vb_ff;

   always_ff @(posedge clock) begin
      sqx_ff <= ax_ff * ax_ff;
      sqy_ff <= ay_ff * ay_ff;
   end

   // ---------------- stage C: sum of squares ----------------
   logic [58:0] sum_ff;
   logic        vc_ff;

   always_ff @(posedge clock) begin
      sum_ff <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
   end

   // ---------------- square root cell chain ----------------
   rgl_pkg::sqrt_word_type chain [CELLS+1];

   always_comb begin
      chain[0].valid = vc_ff;
      chain[0].rad   = {1'b0, sum_ff};
      chain[0].rem   = '0;
      chain[0].root  = '0;
   end

   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      rgl_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .word_in  (chain[g]),
         .word_out (chain[g+1])
      );
   end

   // ---------------- stage D: distance past inner radius ----------------
   logic signed [31:0] diff_ff;
   logic               vd_ff;

   always_ff @(posedge clock) begin
      diff_ff <= $signed({2'b00, chain[CELLS].root}) - {inner_ff[30], inner_ff};
   end

   // ---------------- stage E: times slope ----------------
   logic [47:0] prod_ff;
   logic        neg_ff;
   logic        ve_ff;

   always_ff @(posedge clock) begin
      prod_ff <= diff_ff[30:0] * slope;
      neg_ff  <= diff_ff[31];
   end

   // ---------------- stage F: ratio clamp ----------------
   logic [rgl_pkg::RATIO_W-1:0] ratio_ff;
   logic                        vf_ff;

   always_ff @(posedge clock) begin
      // negative ratio clamps to zero whatever the rounding
      if (neg_ff)
         ratio_ff <= '0;
      else if (prod_ff[47:16] > 32'(rgl_pkg::ONE_FX))
         ratio_ff <= rgl_pkg::ONE_FX;
      else
         ratio_ff <= prod_ff[32:16];
   end

   // ---------------- stage G: blend products ----------------
   logic [40:0] mix_in_ff, mix_out_ff;
   logic        vg_ff;

   always_ff @(posedge clock) begin
      mix_in_ff  <= lin_ff  * (rgl_pkg::ONE_FX - ratio_ff);
      mix_out_ff <= lout_ff * ratio_ff;
   end

   // ---------------- stage H: round and output ----------------
   logic [40:0] mix_sum;
   logic [7:0]  luma_ff;
   logic        strobe_ff;

   // levels are clamped, so the sum never passes 255.5 whole
   assign mix_sum = mix_in_ff + mix_out_ff + 41'h0080000000;

   always_ff @(posedge clock) begin
      luma_ff <= mix_sum[39:32];
   end

   // ---------------- valid pipeline ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff     <= 1'b0;
         vb_ff     <= 1'b0;
         vc_ff     <= 1'b0;
         vd_ff     <= 1'b0;
         ve_ff     <= 1'b0;
         vf_ff     <= 1'b0;
         vg_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         va_ff     <= accept;
         vb_ff     <= va_ff;
         vc_ff     <= vb_ff;
         vd_ff     <= chain[CELLS].valid;
         ve_ff     <= vd_ff;
         vf_ff     <= ve_ff;
         vg_ff     <= vf_ff;
         strobe_ff <= vg_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_luma   = luma_ff;

   // ---------------- checks ----------------
   `RGL_ASSERT_IMPLY(a_latency, accept, ##LATENCY rsp_strobe)
   `RGL_ASSERT_NEXT(a_radius_busy, radius_wr, busy)
   `RGL_ASSERT_IMPLY(a_slope_range, 1'b1, slope != '0 && slope <= rgl_pkg::ONE_FX)

endmodule
